// ----- hw/rtl/round_robin_process_scheduler_defines.svh -----
// Assertion macros for the round-robin process scheduler.
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RRPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rrps assertion failed");
`define RRPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rrps assertion failed");
`else
`define RRPS_ASSERT(lbl, prop)
`define RRPS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hw/rtl/rrps_pkg.sv -----
// Package: constants, types and helpers for the round-robin process scheduler.
package rrps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 16;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SLICE_W     = 8;
  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

  typedef logic [PID_BITS-1:0] pid_t;
  typedef logic [QIDX_W-1:0]   qidx_t;
  typedef logic [SLICE_W-1:0]  slice_t;

  typedef enum logic [2:0] {
    EV_WORKING  = 3'd0,
    EV_FINISHED = 3'd1,
    EV_QUEUED   = 3'd2,
    EV_WAITING  = 3'd3,
    EV_FULL     = 3'd4,
    EV_ROTATED  = 3'd5
  } rrps_event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_POP,
    S_DONE
  } rrps_state_t;

  typedef struct packed {
    logic  wr_en;
    qidx_t wr_addr;
    pid_t  wr_data;
    logic  rd_en;
    qidx_t rd_addr;
  } rrps_qreq_t;

  typedef struct packed {
    logic        granted;
    rrps_event_t ev;
    pid_t        running_pid;
    logic        running_valid;
  } rrps_result_t;

  function automatic qidx_t next_slot(qidx_t i);
    next_slot = (i == qidx_t'(QUEUE_DEPTH - 1)) ? '0 : i + qidx_t'(1);
  endfunction

endpackage

// ----- hw/rtl/rrps_wait_queue.sv -----
// Wait queue storage: one write port, one registered read port.
module rrps_wait_queue
  import rrps_pkg::*;
(
  input  logic       clk,
  input  rrps_qreq_t qreq,
  output pid_t       rd_data
);

  pid_t mem [QUEUE_DEPTH];
  pid_t rd_data_r;

  always_ff @(posedge clk) begin
    if (qreq.wr_en) begin
      mem[qreq.wr_addr] <= qreq.wr_data;
    end
    if (qreq.rd_en) begin
      rd_data_r <= mem[qreq.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/rrps_seq.sv -----
// Sequencer: scheduling state, queue pointers and the pid compares.
module rrps_seq
  import rrps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pid_t         in_pid,
  input  logic         in_done,
  input  slice_t       slice_length,
  output rrps_qreq_t   qreq,
  input  pid_t         q_rd_data,
  output logic         res_valid,
  input  logic         res_ready,
  output rrps_result_t res
);

  rrps_state_t state_r, state_nxt;
  pid_t        pid_r, pid_nxt;
  logic        done_r, done_nxt;
  pid_t        cur_pid_r, cur_pid_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  slice_t      slice_r, slice_nxt;
  qidx_t       head_r, head_nxt;
  qidx_t       tail_r, tail_nxt;
  qidx_t       scan_r, scan_nxt;
  logic        pend_r, pend_nxt;
  logic        rotate_r, rotate_nxt;
  logic        granted_r, granted_nxt;
  rrps_event_t ev_r, ev_nxt;

  pid_t   eff_pid;
  logic   same;
  logic   q_empty;
  logic   q_full;
  logic   hit;
  slice_t reload;

  assign eff_pid = cur_valid_r ? cur_pid_r : pid_r;
  assign same    = (eff_pid == pid_r);
  assign q_empty = (head_r == tail_r);
  assign q_full  = (next_slot(tail_r) == head_r);
  assign hit     = pend_r && (q_rd_data == pid_r);
  assign reload  = (slice_length == '0) ? slice_t'(1) : slice_length;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (same && slice_r != '0) begin
          state_nxt = (done_r && !q_empty) ? S_POP : S_DONE;
        end else if (same) begin
          state_nxt = q_empty ? S_DONE : S_POP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || (!pend_r && scan_r == tail_r)) state_nxt = S_DONE;
      end
      S_POP:    state_nxt = S_DONE;
      S_DONE:   if (res_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pid_nxt       = pid_r;
    done_nxt      = done_r;
    cur_pid_nxt   = cur_pid_r;
    cur_valid_nxt = cur_valid_r;
    slice_nxt     = slice_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    rotate_nxt    = rotate_r;
    granted_nxt   = granted_r;
    ev_nxt        = ev_r;
    qreq          = '0;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        pid_nxt  = in_pid;
        done_nxt = in_done;
      end
      S_DECIDE: begin
        cur_pid_nxt   = eff_pid;
        cur_valid_nxt = 1'b1;
        granted_nxt   = 1'b0;
        slice_nxt     = reload;
        qreq.rd_addr  = head_r;
        if (same && slice_r != '0) begin
          granted_nxt = 1'b1;
          if (done_r) begin
            ev_nxt     = EV_FINISHED;
            rotate_nxt = 1'b0;
            if (q_empty) begin
              cur_valid_nxt = 1'b0;
              cur_pid_nxt   = '0;
            end else begin
              qreq.rd_en = 1'b1;
            end
          end else begin
            ev_nxt    = EV_WORKING;
            slice_nxt = slice_r - slice_t'(1);
          end
        end else if (same) begin
          ev_nxt     = EV_ROTATED;
          rotate_nxt = 1'b1;
          qreq.rd_en = !q_empty;
        end else begin
          scan_nxt = head_r;
        end
      end
      S_SCAN: begin
        qreq.rd_addr = scan_r;
        if (hit) begin
          ev_nxt = EV_WAITING;
        end else if (!pend_r && scan_r == tail_r) begin
          if (q_full) begin
            ev_nxt = EV_FULL;
          end else begin
            ev_nxt        = EV_QUEUED;
            qreq.wr_en    = 1'b1;
            qreq.wr_addr  = tail_r;
            qreq.wr_data  = pid_r;
            tail_nxt      = next_slot(tail_r);
          end
        end else if (scan_r != tail_r) begin
          qreq.rd_en = 1'b1;
          pend_nxt   = 1'b1;
          scan_nxt   = next_slot(scan_r);
        end
      end
      S_POP: begin
        cur_pid_nxt = q_rd_data;
        head_nxt    = next_slot(head_r);
        if (rotate_r) begin
          qreq.wr_en   = 1'b1;
          qreq.wr_addr = tail_r;
          qreq.wr_data = pid_r;
          tail_nxt     = next_slot(tail_r);
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign res.granted       = granted_r;
  assign res.ev            = ev_r;
  assign res.running_pid   = cur_valid_r ? cur_pid_r : '0;
  assign res.running_valid = cur_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_pid_r   <= '0;
      cur_valid_r <= 1'b0;
      slice_r     <= SLICE_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_pid_r   <= cur_pid_nxt;
      cur_valid_r <= cur_valid_nxt;
      slice_r     <= slice_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r     <= pid_nxt;
    done_r    <= done_nxt;
    scan_r    <= scan_nxt;
    rotate_r  <= rotate_nxt;
    granted_r <= granted_nxt;
    ev_r      <= ev_nxt;
  end

endmodule

// ----- hw/rtl/round_robin_process_scheduler.sv -----
// Round-robin process scheduler top level: config register, sequencer, queue, output register.
// An accepted input goes to DECIDE, then to DONE for a served or rotating caller (through POP
// with a queue pop); a denied caller scans the wait queue in SCAN, one entry per cycle.
// One item at a time: the next input is taken once the result is in the output register.
// Synchronous active-low reset: idle, empty queue, slice 10; queue storage is not cleared.
`include "round_robin_process_scheduler_defines.svh"
module round_robin_process_scheduler
  import rrps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pid_t         in_requester_pid,
  input  logic         in_work_done,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_granted,
  output logic [2:0]   out_event_res,
  output pid_t         out_running_pid,
  output logic         out_running_valid,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  slice_t       cfg_data
);

  slice_t       slice_len_r;
  rrps_qreq_t   qreq;
  pid_t         q_rd_data;
  logic         res_valid;
  logic         res_ready;
  rrps_result_t res;
  logic         out_valid_r;
  rrps_result_t out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= SLICE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slice_len_r <= cfg_data;
    end
  end

  rrps_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pid       (in_requester_pid),
    .in_done      (in_work_done),
    .slice_length (slice_len_r),
    .qreq         (qreq),
    .q_rd_data    (q_rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  rrps_wait_queue u_queue (
    .clk     (clk),
    .qreq    (qreq),
    .rd_data (q_rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_r.granted;
  assign out_event_res     = out_r.ev;
  assign out_running_pid   = out_r.running_pid;
  assign out_running_valid = out_r.running_valid;

  `RRPS_ASSERT(a_idle_pid_zero, out_valid && !out_running_valid |-> out_running_pid == '0)
  `RRPS_ASSERT(a_grant_event, out_valid && out_granted |-> out_event_res == EV_WORKING || out_event_res == EV_FINISHED)
  `RRPS_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
  `RRPS_ASSERT(a_rotate_running, out_valid && out_event_res == EV_ROTATED |-> out_running_valid)
  `RRPS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !out_valid)

endmodule
